// File: hdl/qss_pkg.sv
// ----------------------------------------------------------------------------
// qss_pkg
// Shared types and constants for the sorter's cells and its control.
// ----------------------------------------------------------------------------
`default_nettype none

package qss_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/qss_cell.sv
// ----------------------------------------------------------------------------
// qss_cell
// One slot of the sorting chain: holds one element, takes part in ordered
// insertion and shifts toward the head while the set is read out.
// ----------------------------------------------------------------------------
`default_nettype none

module qss_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire qss_pkg::cell_ctrl_t ctrl,
	input  wire logic                occupied,
	input  wire qss_pkg::data_t      in_value,
	input  wire qss_pkg::data_t      prev_value,
	input  wire logic                prev_lt,
	input  wire qss_pkg::data_t      next_value,
	output qss_pkg::data_t           value,
	output logic                     lt
);

	qss_pkg::data_t value_q;

	assign lt    = !occupied || (in_value < value_q);
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctrl.ins && lt) begin
			value_q <= prev_lt ? prev_value : in_value;
		end else if (ctrl.pop) begin
			value_q <= next_value;
		end
	end

endmodule

`default_nettype wire

// File: hdl/quicksort_sorter_unit.sv
// ----------------------------------------------------------------------------
// quicksort_sorter_unit
// Collects a set of signed values, keeps them in ascending order in a chain
// of cells, and streams them out with the final one marked.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata           | tlast       | tuser
//  s_axis   | in        | value [31:0]    | is_last     | -
//  m_axis   | out       | sorted_value    | end_of_run  | overflowed
//
// Each accepted item is inserted as it is accepted: every cell compares the new
// value against its own element at once and the larger ones move up a slot.
// After the item marked last, one result is offered per cycle from the head
// cell while m_tready is high. Input is held off while results are being
// delivered; m_tready low stalls the readout without losing anything. Reset
// empties the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_sorter_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] value
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [31:0] sorted_value
	output logic             m_tlast,
	output logic             m_tuser   // [0] overflowed
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	qss_pkg::state_t     state_q, state_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                ovf_q, ovf_d;
	qss_pkg::cell_ctrl_t ctrl;
	logic                full;

	qss_pkg::data_t      cell_value [DEPTH];
	logic                cell_lt    [DEPTH];
	qss_pkg::data_t      in_value;

	assign in_value = qss_pkg::data_t'(s_tdata);
	assign full     = (cnt_q == CNT_W'(DEPTH));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		ctrl     = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			qss_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (full) begin
						ovf_d = 1'b1;
					end else begin
						ctrl.ins = 1'b1;
						cnt_d    = cnt_q + CNT_W'(1);
					end
					if (s_tlast) begin
						state_d = qss_pkg::ST_EMIT;
					end
				end
			end
			qss_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					ctrl.pop = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_d = qss_pkg::ST_LOAD;
						ovf_d   = 1'b0;
					end
				end
			end
			default: begin
				state_d = qss_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qss_pkg::ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		qss_pkg::data_t prev_value, next_value;
		logic           prev_lt;

		if (i == 0) begin : g_head
			assign prev_value = '0;
			assign prev_lt    = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_lt    = cell_lt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_value = '0;
		end else begin : g_link
			assign next_value = cell_value[i+1];
		end

		qss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.occupied   (cnt_q > CNT_W'(i)),
			.in_value   (in_value),
			.prev_value (prev_value),
			.prev_lt    (prev_lt),
			.next_value (next_value),
			.value      (cell_value[i]),
			.lt         (cell_lt[i])
		);
	end

	assign m_tdata = 32'(cell_value[0]);
	assign m_tlast = (cnt_q == CNT_W'(1));
	assign m_tuser = ovf_q;

endmodule

`default_nettype wire

// File: tb/quicksort_sorter_unit_tb.sv
// ----------------------------------------------------------------------------
// quicksort_sorter_unit_tb
// Feeds sets of signed values into the sorter and checks every value it
// streams back against an in-bench ascending sort of the same set, along
// with the end marker and the overflow flag. Both stream sides idle at
// random, and one long readout stall forces the input side to back up.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_sorter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef qss_pkg::data_t data_t;

	localparam int unsigned DEPTH = 64;

	typedef struct {
		data_t value;
		logic  end_of_run;
		logic  overflowed;
	} sorted_item_t;

	class sorted_set_tracker;
		int unsigned  store_depth;
		data_t        set_values[$];
		bit           set_overflow;
		sorted_item_t sorted_out_q[$];
		int unsigned  mismatches;
		int unsigned  sets_done;
		int unsigned  sets_overflowed;
		int unsigned  elements_in;
		int unsigned  results_out;

		function new(int unsigned depth);
			store_depth = depth;
		endfunction

		function void take_element(data_t value, logic last);
			data_t        key;
			int           i;
			int           j;
			sorted_item_t item;
			elements_in++;
			if (set_values.size() < store_depth) begin
				set_values.push_back(value);
			end else begin
				set_overflow = 1'b1;
			end
			if (!last) begin
				return;
			end
			for (i = 1; i < set_values.size(); i++) begin
				key = set_values[i];
				j = i - 1;
				while (j >= 0 && set_values[j] > key) begin
					set_values[j + 1] = set_values[j];
					j--;
				end
				set_values[j + 1] = key;
			end
			for (i = 0; i < set_values.size(); i++) begin
				item.value      = set_values[i];
				item.end_of_run = (i == set_values.size() - 1);
				item.overflowed = set_overflow;
				sorted_out_q.push_back(item);
			end
			sets_done++;
			if (set_overflow) begin
				sets_overflowed++;
			end
			set_values.delete();
			set_overflow = 1'b0;
		endfunction

		function void check_output(data_t value, logic last, logic ovf);
			sorted_item_t want;
			results_out++;
			if (sorted_out_q.size() == 0) begin
				$display("%0t: unexpected result value %0d last %0b overflow %0b",
					$time, value, last, ovf);
				mismatches++;
				return;
			end
			want = sorted_out_q.pop_front();
			if (value !== want.value) begin
				$display("%0t: sorted value expected %0d actual %0d",
					$time, want.value, value);
				mismatches++;
			end
			if (last !== want.end_of_run) begin
				$display("%0t: end of run expected %0b actual %0b",
					$time, want.end_of_run, last);
				mismatches++;
			end
			if (ovf !== want.overflowed) begin
				$display("%0t: overflow flag expected %0b actual %0b",
					$time, want.overflowed, ovf);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return sorted_out_q.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	sorted_set_tracker sorter_sb;
	bit                tx_eager;
	bit                held_off;

	quicksort_sorter_unit #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Signals only change at rising edges, so the falling edge sees exactly
	// what the next rising edge will act on.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sorter_sb.take_element(data_t'(s_tdata), s_tlast);
			end
			if (m_tvalid && m_tready) begin
				sorter_sb.check_output(data_t'(m_tdata), m_tlast, m_tuser);
			end
		end
	end

	task automatic send_item(data_t value, logic last);
		int unsigned gap;
		gap = tx_eager ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic send_set(data_t values[$]);
		int i;
		for (i = 0; i < values.size(); i++) begin
			send_item(values[i], i == values.size() - 1);
		end
	endtask

	function automatic data_t pick_value();
		case ($urandom_range(0, 3))
			0: return data_t'($urandom_range(0, 8)) - data_t'(4);
			1: begin
				case ($urandom_range(0, 3))
					0: return data_t'(32'h8000_0000);
					1: return data_t'(32'h7fff_ffff);
					2: return data_t'(32'hffff_ffff);
					default: return data_t'(0);
				endcase
			end
			default: return data_t'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned rx_gap;
		@(posedge arst_n);
		forever begin
			if (!held_off && sorter_sb.results_out >= 90) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			rx_gap = ((sorter_sb.results_out / 40) % 2 == 1) ? 0 : $urandom_range(0, 15);
			if (rx_gap > 0) begin
				m_tready <= 1'b0;
				repeat (rx_gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		data_t       set_q[$];
		int unsigned random_items;
		int unsigned set_idx;
		int unsigned set_size;
		int unsigned k;
		sorter_sb = new(DEPTH);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_eager = 1'b0;
		set_q = '{data_t'(7)};
		send_set(set_q);
		set_q = '{data_t'(32'h7fff_ffff), data_t'(32'h8000_0000), data_t'(0),
			data_t'(-1), data_t'(1), data_t'(-1), data_t'(32'h8000_0000)};
		send_set(set_q);
		tx_eager = 1'b1;
		set_q = '{data_t'(1), data_t'(2), data_t'(3), data_t'(4)};
		send_set(set_q);
		set_q = '{data_t'(4), data_t'(3), data_t'(2), data_t'(1)};
		send_set(set_q);
		tx_eager = 1'b0;
		set_q = '{data_t'(-5), data_t'(-5), data_t'(-5)};
		send_set(set_q);

		// Three sets reach the store limit: one fills it exactly, one drops
		// only its final item, and one drops several before its end.
		random_items = 0;
		set_idx = 0;
		while (random_items < 300) begin
			case (set_idx)
				2: set_size = DEPTH;
				5: set_size = DEPTH + 1;
				9: set_size = DEPTH + 6;
				default: set_size = $urandom_range(1, 12);
			endcase
			set_q.delete();
			for (k = 0; k < set_size; k++) begin
				set_q.push_back(pick_value());
			end
			tx_eager = ($urandom_range(0, 3) == 0);
			send_set(set_q);
			random_items += set_size;
			set_idx++;
		end
		s_tvalid <= 1'b0;

		while (sorter_sb.outstanding() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("Sorted %0d sets from %0d input transfers into %0d output transfers.",
			sorter_sb.sets_done, sorter_sb.elements_in, sorter_sb.results_out);
		$display("%0d sets overran the store; %0d mismatches were found.",
			sorter_sb.sets_overflowed, sorter_sb.mismatches);
		if (sorter_sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
